// File: rtl/s2i_pkg.sv
// ----------------------------------------------------------------------------
// s2i_pkg
// Shared types, codes and helpers for the string-to-integer parser.
// ----------------------------------------------------------------------------
`default_nettype none

package s2i_pkg;

    localparam int POS_W = 16;

    typedef logic [POS_W-1:0] t_pos;

    localparam t_pos POS_MAX = {POS_W{1'b1}};

    localparam logic [5:0] BASE_MAX = 6'd36;
    localparam logic [5:0] BASE_OCT = 6'd8;
    localparam logic [5:0] BASE_DEC = 6'd10;
    localparam logic [5:0] BASE_HEX = 6'd16;
    localparam logic [5:0] BASE_ONE = 6'd1;
    localparam logic [5:0] BASE_AUTO = 6'd0;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_X  = 8'h78;
    localparam logic [7:0] CH_LO_Z  = 8'h7A;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_X  = 8'h58;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;

    localparam logic [5:0] DIG_NONE = 6'd36;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SPACE,
        PH_SIGNED,
        PH_ZERO,
        PH_XSEEN,
        PH_DIGITS
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_BASE  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef struct packed {
        logic [7:0] ch;
        logic       start_req;
        logic [5:0] radix;
        logic       signed_mode;
        logic       wide;
    } t_in_item;

    typedef struct packed {
        logic [63:0] value;
        logic [1:0]  status;
        logic [15:0] consumed;
    } t_out_item;

    // Digit value of a character in bases up to 36; DIG_NONE when not a digit.
    function automatic logic [5:0] digit_value(input logic [7:0] c);
        logic [7:0] d;
        d = {2'b00, DIG_NONE};
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d = c - CH_ZERO;
        end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
            d = c - CH_LO_A + 8'd10;
        end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
            d = c - CH_UP_A + 8'd10;
        end
        return d[5:0];
    endfunction

endpackage

`default_nettype wire

// File: rtl/string_to_integer_parser.sv
// ----------------------------------------------------------------------------
// string_to_integer_parser
// Converts a character stream to a 32- or 64-bit integer, strtol style.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                   Payload
//  -------   ---------  --------------------------  ---------------------------
//  in        sink       i_in_valid / o_in_stall     i_in_data  (ch, start_req,
//                                                    radix, signed_mode, wide)
//  out       source     o_out_valid / i_out_stall   o_out_data (value, status,
//                                                    consumed)
//
//  One character transaction is taken per cycle while o_in_stall is low; its
//  whole parse step (digit decode, a 64 x 6 multiply and add, range compare,
//  saturation) completes in the accepting cycle; any result is registered.
//  An output register plus one skid entry decouple the sides: o_in_stall
//  rises only once the stalled output has a second result queued in the skid.
//  Synchronous reset (i_rst_n low) returns the parser to idle, empties both.
// ----------------------------------------------------------------------------
`default_nettype none

module string_to_integer_parser (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_stall,
    input  wire s2i_pkg::t_in_item i_in_data,
    output logic                  o_out_valid,
    input  wire                   i_out_stall,
    output s2i_pkg::t_out_item    o_out_data
);

    // Conversion state
    s2i_pkg::t_phase r_phase, n_phase;
    logic [63:0]     r_acc, n_acc;        // magnitude accumulated so far
    logic [5:0]      r_base, n_base;      // active base, 0 while still auto
    logic            r_neg, n_neg;
    logic            r_valid, n_valid;    // at least one digit seen
    logic            r_ovf, n_ovf;
    logic            r_sg, n_sg;
    logic            r_wd, n_wd;
    s2i_pkg::t_pos   r_pos, n_pos;        // characters seen, saturating
    s2i_pkg::t_pos   r_dend, n_dend;      // position of the last digit

    // Output register and skid entry
    logic               r_out_valid;
    s2i_pkg::t_out_item r_out;
    logic               r_skd_valid;
    s2i_pkg::t_out_item r_skd;

    logic               in_acc;
    logic               res_v;
    s2i_pkg::t_out_item res_d;

    assign o_in_stall  = r_skd_valid;
    assign in_acc      = i_in_valid && !r_skd_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ------------------------------------------------------------------
    // Parse step: everything one character does, in a single pass.
    // ------------------------------------------------------------------
    always_comb begin : p_step
        logic [7:0]  c;
        logic [5:0]  dv;
        logic        first;
        logic        take;
        logic        emit;
        logic        bad;
        logic        ovf_e;
        logic [63:0] lim;
        logic [70:0] prod;
        logic [70:0] sum;
        logic [63:0] v;

        n_phase = r_phase;
        n_acc   = r_acc;
        n_base  = r_base;
        n_neg   = r_neg;
        n_valid = r_valid;
        n_ovf   = r_ovf;
        n_sg    = r_sg;
        n_wd    = r_wd;
        n_pos   = r_pos;
        n_dend  = r_dend;
        res_v   = 1'b0;
        res_d   = '0;

        c     = i_in_data.ch;
        dv    = s2i_pkg::digit_value(c);
        first = 1'b0;
        take  = 1'b0;
        emit  = 1'b0;
        bad   = 1'b0;
        ovf_e = 1'b0;
        lim   = '0;
        prod  = '0;
        sum   = '0;
        v     = '0;

        if (in_acc) begin
            // Open a new conversion; any running one is dropped.
            if (i_in_data.start_req) begin
                n_sg    = i_in_data.signed_mode;
                n_wd    = i_in_data.wide;
                n_neg   = 1'b0;
                n_valid = 1'b0;
                n_ovf   = 1'b0;
                n_acc   = '0;
                n_pos   = '0;
                n_dend  = '0;
                n_base  = i_in_data.radix;
                n_phase = s2i_pkg::PH_SPACE;
                bad = (i_in_data.radix == s2i_pkg::BASE_ONE) ||
                      (i_in_data.radix > s2i_pkg::BASE_MAX);
                if (bad) begin
                    res_v          = 1'b1;
                    res_d.status   = s2i_pkg::ST_BASE;
                    n_phase        = s2i_pkg::PH_IDLE;
                end
            end

            if (n_phase != s2i_pkg::PH_IDLE) begin
                if (n_pos != s2i_pkg::POS_MAX) begin
                    n_pos = n_pos + s2i_pkg::t_pos'(1);
                end

                unique case (n_phase)
                    s2i_pkg::PH_SPACE: begin
                        if (c == s2i_pkg::CH_SPACE ||
                            (c >= s2i_pkg::CH_TAB && c <= s2i_pkg::CH_CR)) begin
                            // skip white space
                        end else if (c == s2i_pkg::CH_MINUS) begin
                            n_neg   = 1'b1;
                            n_phase = s2i_pkg::PH_SIGNED;
                        end else if (c == s2i_pkg::CH_PLUS) begin
                            n_phase = s2i_pkg::PH_SIGNED;
                        end else begin
                            first = 1'b1;
                        end
                    end
                    s2i_pkg::PH_SIGNED: begin
                        first = 1'b1;
                    end
                    s2i_pkg::PH_ZERO: begin
                        if (c == s2i_pkg::CH_LO_X || c == s2i_pkg::CH_UP_X) begin
                            n_phase = s2i_pkg::PH_XSEEN;
                        end else begin
                            if (n_base == s2i_pkg::BASE_AUTO) begin
                                n_base = s2i_pkg::BASE_OCT;
                            end
                            take = 1'b1;
                        end
                    end
                    s2i_pkg::PH_XSEEN: begin
                        // Prefix counts only when a hex digit follows.
                        if (dv < s2i_pkg::BASE_HEX) begin
                            n_base = s2i_pkg::BASE_HEX;
                            take   = 1'b1;
                        end else begin
                            emit = 1'b1;
                        end
                    end
                    default: begin
                        take = 1'b1;
                    end
                endcase

                // First significant character: a lone zero may be a prefix
                // and is counted as a parsed digit either way.
                if (first) begin
                    if ((n_base == s2i_pkg::BASE_AUTO || n_base == s2i_pkg::BASE_HEX) &&
                        c == s2i_pkg::CH_ZERO) begin
                        n_valid = 1'b1;
                        n_dend  = n_pos;
                        n_phase = s2i_pkg::PH_ZERO;
                    end else begin
                        if (n_base == s2i_pkg::BASE_AUTO) begin
                            n_base = s2i_pkg::BASE_DEC;
                        end
                        take = 1'b1;
                    end
                end
            end
        end

        // Magnitude limit of the selected mode
        if (n_wd) begin
            lim = n_sg ? 64'h8000_0000_0000_0000 : 64'hFFFF_FFFF_FFFF_FFFF;
        end else begin
            lim = n_sg ? 64'h0000_0000_8000_0000 : 64'h0000_0000_FFFF_FFFF;
        end

        // acc * base + digit > limit is the overflow test, exact in 71 bits
        prod = {7'd0, n_acc} * {65'd0, n_base};
        sum  = prod + {65'd0, dv};

        if (take) begin
            if (dv >= n_base) begin
                emit = 1'b1;
            end else begin
                n_valid = 1'b1;
                n_dend  = n_pos;
                if (!n_ovf) begin
                    if (sum > {7'd0, lim}) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_acc = sum[63:0];
                    end
                end
                n_phase = s2i_pkg::PH_DIGITS;
            end
        end

        if (emit) begin
            // A positive signed magnitude equal to the limit is one past MAX.
            ovf_e = n_ovf || (n_sg && !n_neg && n_acc == lim);
            if (ovf_e) begin
                if (n_sg) begin
                    if (n_wd) begin
                        v = n_neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
                    end else begin
                        v = n_neg ? 64'hFFFF_FFFF_8000_0000 : 64'h0000_0000_7FFF_FFFF;
                    end
                end else begin
                    v = n_wd ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h0000_0000_FFFF_FFFF;
                end
            end else begin
                v = n_neg ? (64'd0 - n_acc) : n_acc;
                if (!n_sg && !n_wd) begin
                    v[63:32] = '0;
                end
            end
            res_v          = 1'b1;
            res_d.value    = v;
            res_d.status   = ovf_e ? s2i_pkg::ST_RANGE : s2i_pkg::ST_OK;
            res_d.consumed = n_valid ? n_dend : '0;
            n_phase        = s2i_pkg::PH_IDLE;
        end
    end

    // ------------------------------------------------------------------
    // State registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= s2i_pkg::PH_IDLE;
            r_acc   <= '0;
            r_base  <= '0;
            r_neg   <= 1'b0;
            r_valid <= 1'b0;
            r_ovf   <= 1'b0;
            r_sg    <= 1'b0;
            r_wd    <= 1'b0;
            r_pos   <= '0;
            r_dend  <= '0;
        end else begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_base  <= n_base;
            r_neg   <= n_neg;
            r_valid <= n_valid;
            r_ovf   <= n_ovf;
            r_sg    <= n_sg;
            r_wd    <= n_wd;
            r_pos   <= n_pos;
            r_dend  <= n_dend;
        end
    end

    // ------------------------------------------------------------------
    // Output register with one skid entry behind it
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skd_valid <= 1'b0;
        end else if (r_skd_valid) begin
            // No new transaction is taken; drain the skid entry.
            if (!i_out_stall) begin
                r_out       <= r_skd;
                r_skd_valid <= 1'b0;
            end
        end else if (res_v) begin
            if (!r_out_valid || !i_out_stall) begin
                r_out       <= res_d;
                r_out_valid <= 1'b1;
            end else begin
                r_skd       <= res_d;
                r_skd_valid <= 1'b1;
            end
        end else if (r_out_valid && !i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

endmodule

`default_nettype wire
